>>> src/gelu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gelu_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 10;

  // config port
  localparam int          ADDR_W        = 3;
  localparam logic [0:0]  REG_FAST_MODE = 1'b0;

  // gate is Q0.16, one extra bit so that exactly 1.0 is representable
  localparam int             GATE_W    = 17;
  localparam logic [16:0]    GATE_ONE  = 17'h10000;
  localparam logic [16:0]    GATE_HALF = 17'h08000;
  localparam int             TAB_W     = 16;
  localparam int             TAB_LAST  = 16;

  // fast mode: u = (COEF_LIN*a + COEF_CUB*a^3) >> 16
  localparam int          COEF_LIN_W = 17;
  localparam int          COEF_CUB_W = 13;
  localparam logic [16:0] COEF_LIN   = 17'd104580;
  localparam logic [12:0] COEF_CUB   = 13'd4676;

  // standard normal CDF, steps of 0.25 from 0 to 4
  function automatic logic [TAB_W-1:0] phi_lut(input logic [4:0] i);
    logic [TAB_W-1:0] v;
    case (i)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd39237;
      5'd2:    v = 16'd45316;
      5'd3:    v = 16'd50684;
      5'd4:    v = 16'd55138;
      5'd5:    v = 16'd58612;
      5'd6:    v = 16'd61158;
      5'd7:    v = 16'd62911;
      5'd8:    v = 16'd64045;
      5'd9:    v = 16'd64735;
      5'd10:   v = 16'd65129;
      5'd11:   v = 16'd65341;
      5'd12:   v = 16'd65448;
      5'd13:   v = 16'd65498;
      5'd14:   v = 16'd65521;
      5'd15:   v = 16'd65530;
      default: v = 16'd65534;
    endcase
    return v;
  endfunction

  // logistic function, steps of 0.5 from 0 to 8
  function automatic logic [TAB_W-1:0] logistic_lut(input logic [4:0] i);
    logic [TAB_W-1:0] v;
    case (i)
      5'd0:    v = 16'd32768;
      5'd1:    v = 16'd40793;
      5'd2:    v = 16'd47911;
      5'd3:    v = 16'd53581;
      5'd4:    v = 16'd57724;
      5'd5:    v = 16'd60565;
      5'd6:    v = 16'd62428;
      5'd7:    v = 16'd63615;
      5'd8:    v = 16'd64357;
      5'd9:    v = 16'd64809;
      5'd10:   v = 16'd65097;
      5'd11:   v = 16'd65269;
      5'd12:   v = 16'd65374;
      5'd13:   v = 16'd65438;
      5'd14:   v = 16'd65476;
      5'd15:   v = 16'd65500;
      default: v = 16'd65514;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> src/gelu_activation.sv
`timescale 1ns / 1ps
`default_nettype none
// GELU activation, Q5.10 in and out, erf or tanh gate selected by fast_mode.
// Nine register stages lie between input beat and output beat: magnitude, two
// cube multiplies, coefficient multiply, table position, table read,
// interpolation, gate product, sign/output.
// Throughput: one beat per cycle; a stall holds the full stages, empty ones still fill.
// Reset (synchronous, rst high) empties the pipeline and clears fast_mode.

module gelu_activation (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [gelu_pkg::ADDR_W-1:0]          paddr,
  input  wire logic [31:0]                          pwdata,
  output      logic [31:0]                          prdata,
  output      logic                                 pready,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic signed [gelu_pkg::DATA_WIDTH-1:0] x_in,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      logic signed [gelu_pkg::DATA_WIDTH-1:0] y_out
);
  import gelu_pkg::*;

  localparam int AW       = DATA_WIDTH + 1;
  localparam int FAST_LIM = 5 << FRAC_BITS;
  localparam int FW       = $clog2(FAST_LIM);
  localparam int SQ_W     = 2 * FW - FRAC_BITS;
  localparam int CUBE_W   = SQ_W + FW - FRAC_BITS;
  localparam int P1_W     = COEF_LIN_W + FW;
  localparam int P2_W     = COEF_CUB_W + CUBE_W;
  localparam int SUM_W    = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
  localparam int U_W      = SUM_W - 16;
  localparam int PW       = ((AW + 2) > (U_W + 1)) ? (AW + 2) : (U_W + 1);
  localparam int IDX_W    = PW - FRAC_BITS;
  localparam int MP_W     = AW + GATE_W;

  // ---------------- config register ----------------
  logic fast_mode;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[ADDR_W-1:2] == REG_FAST_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      fast_mode <= 1'b0;
    end else if (cfg_wr) begin
      fast_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_FAST_MODE) begin
      prdata[0] = fast_mode;
    end
  end

  // ---------------- stage enables ----------------
  logic v1, v2, v3, v4, v5, v6, v7, v8, v9;
  logic en1, en2, en3, en4, en5, en6, en7, en8, en9;

  assign en9 = !v9 || out_ready;
  assign en8 = !v8 || en9;
  assign en7 = !v7 || en8;
  assign en6 = !v6 || en7;
  assign en5 = !v5 || en6;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign in_ready  = en1;
  assign out_valid = v9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
      v6 <= 1'b0; v7 <= 1'b0; v8 <= 1'b0; v9 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) v5 <= v4;
      if (en6) v6 <= v5;
      if (en7) v7 <= v6;
      if (en8) v8 <= v7;
      if (en9) v9 <= v8;
    end
  end

  // ---------------- stage 1: magnitude ----------------
  logic          neg1, fm1;
  logic [AW-1:0] a1;

  always_ff @(posedge clk) begin
    if (en1) begin
      neg1 <= x_in[DATA_WIDTH-1];
      fm1  <= fast_mode;
      // most negative code maps to its exact magnitude
      a1   <= x_in[DATA_WIDTH-1] ? ({1'b1, {DATA_WIDTH{1'b0}}} - {1'b0, x_in})
                                 : {1'b0, x_in};
    end
  end

  // ---------------- stage 2: a^2, linear term ----------------
  logic [FW-1:0]     af1;
  logic [2*FW-1:0]   sq_full;
  logic [P1_W-1:0]   p1_full;
  logic              neg2, fm2, big2;
  logic [AW-1:0]     a2;
  logic [SQ_W-1:0]   sq2;
  logic [P1_W-1:0]   p1_2;

  assign af1     = a1[FW-1:0];
  assign sq_full = af1 * af1;
  assign p1_full = P1_W'(COEF_LIN) * P1_W'(af1);

  always_ff @(posedge clk) begin
    if (en2) begin
      neg2 <= neg1;
      fm2  <= fm1;
      a2   <= a1;
      big2 <= (a1 >= AW'(FAST_LIM));
      sq2  <= sq_full[2*FW-1:FRAC_BITS];
      p1_2 <= p1_full;
    end
  end

  // ---------------- stage 3: a^3 ----------------
  logic [SQ_W+FW-1:0] cube_full;
  logic               neg3, fm3, big3;
  logic [AW-1:0]      a3;
  logic [CUBE_W-1:0]  cube3;
  logic [P1_W-1:0]    p1_3;

  assign cube_full = (SQ_W+FW)'(sq2) * (SQ_W+FW)'(a2[FW-1:0]);

  always_ff @(posedge clk) begin
    if (en3) begin
      neg3  <= neg2;
      fm3   <= fm2;
      big3  <= big2;
      a3    <= a2;
      cube3 <= cube_full[SQ_W+FW-1:FRAC_BITS];
      p1_3  <= p1_2;
    end
  end

  // ---------------- stage 4: cubic term ----------------
  logic [P2_W-1:0] p2_full;
  logic            neg4, fm4, big4;
  logic [AW-1:0]   a4;
  logic [P1_W-1:0] p1_4;
  logic [P2_W-1:0] p2_4;

  assign p2_full = P2_W'(COEF_CUB) * P2_W'(cube3);

  always_ff @(posedge clk) begin
    if (en4) begin
      neg4 <= neg3;
      fm4  <= fm3;
      big4 <= big3;
      a4   <= a3;
      p1_4 <= p1_3;
      p2_4 <= p2_full;
    end
  end

  // ---------------- stage 5: table position ----------------
  logic [SUM_W-1:0]     usum;
  logic [PW-1:0]        pos;
  logic [IDX_W-1:0]     idx;
  logic                 neg5, fm5, sat5;
  logic [AW-1:0]        a5;
  logic [3:0]           ti5;
  logic [FRAC_BITS-1:0] frac5;

  assign usum = SUM_W'(p1_4) + SUM_W'(p2_4);
  assign pos  = fm4 ? PW'({usum[SUM_W-1:16], 1'b0}) : PW'({a4, 2'b00});
  assign idx  = pos[PW-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en5) begin
      neg5  <= neg4;
      fm5   <= fm4;
      a5    <= a4;
      // past the last entry the gate is exactly one
      sat5  <= (fm4 && big4) || (idx >= IDX_W'(TAB_LAST));
      ti5   <= idx[3:0];
      frac5 <= pos[FRAC_BITS-1:0];
    end
  end

  // ---------------- stage 6: table read ----------------
  logic [TAB_W-1:0]     lo_c, hi_c;
  logic                 neg6, sat6;
  logic [AW-1:0]        a6;
  logic [TAB_W-1:0]     lo6, diff6;
  logic [FRAC_BITS-1:0] frac6;

  assign lo_c = fm5 ? logistic_lut({1'b0, ti5}) : phi_lut({1'b0, ti5});
  assign hi_c = fm5 ? logistic_lut({1'b0, ti5} + 5'd1) : phi_lut({1'b0, ti5} + 5'd1);

  always_ff @(posedge clk) begin
    if (en6) begin
      neg6  <= neg5;
      sat6  <= sat5;
      a6    <= a5;
      lo6   <= lo_c;
      diff6 <= hi_c - lo_c;
      frac6 <= frac5;
    end
  end

  // ---------------- stage 7: interpolation, sign fold ----------------
  logic [TAB_W+FRAC_BITS-1:0] ip_full;
  logic [GATE_W-1:0]          g_c;
  logic                       neg7;
  logic [AW-1:0]              a7;
  logic [GATE_W-1:0]          g7;

  assign ip_full = (TAB_W+FRAC_BITS)'(diff6) * (TAB_W+FRAC_BITS)'(frac6);
  assign g_c     = sat6 ? GATE_ONE
                        : ({1'b0, lo6} + {1'b0, ip_full[TAB_W+FRAC_BITS-1:FRAC_BITS]});

  always_ff @(posedge clk) begin
    if (en7) begin
      neg7 <= neg6;
      a7   <= a6;
      // G(-a) = 1 - G(a)
      g7   <= neg6 ? (GATE_ONE - g_c) : g_c;
    end
  end

  // ---------------- stage 8: magnitude * gate ----------------
  logic [MP_W-1:0] mp;
  logic            neg8;
  logic [AW-1:0]   mag8;

  assign mp = MP_W'(a7) * MP_W'(g7) + MP_W'(GATE_HALF);

  always_ff @(posedge clk) begin
    if (en8) begin
      neg8 <= neg7;
      mag8 <= mp[AW+15:16];
    end
  end

  // ---------------- stage 9: output register ----------------
  logic [AW-1:0] negmag;

  assign negmag = AW'(0) - mag8;

  always_ff @(posedge clk) begin
    if (en9) begin
      y_out <= neg8 ? negmag[DATA_WIDTH-1:0] : mag8[DATA_WIDTH-1:0];
    end
  end

  // ---------------- assertions ----------------
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> v1)
    else $error("accepted beat did not enter stage 1");

  a_drain_to_out: assert property (@(posedge clk) disable iff (rst)
    v8 && en9 |=> out_valid)
    else $error("stage 8 beat lost on its way to the output");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && v5 && v6 && v7 && v8 && v9 && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline is full and stalled");

  a_gate_range: assert property (@(posedge clk) disable iff (rst)
    v7 |-> (g7 <= GATE_ONE))
    else $error("gate above one");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    v8 |-> (mag8 <= AW'(1 << (DATA_WIDTH - 1))))
    else $error("product magnitude out of range");

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import gelu_pkg::*;

  localparam int LATENCY        = 9;
  localparam int DRAIN_CYCLES   = 3 * LATENCY;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int REG_SPARE      = 1;  // no register lives here; writes must be dropped
  localparam logic MODE_ERF     = 1'b0;
  localparam logic MODE_TANH    = 1'b1;

  localparam logic [63:0] Q16_ONE   = 64'd65536;
  localparam logic [63:0] Q16_HALF  = 64'd32768;
  localparam logic [63:0] K_LINEAR  = 64'd104580;  // 1.59576904 in Q1.16
  localparam logic [63:0] K_CUBIC   = 64'd4676;    // 0.0713548 in Q0.16
  localparam int          LAST_KNOT = 16;

  // Phi(x) at 0, 0.25, ... 4.0
  localparam logic [15:0] PHI_Q16 [17] = '{
    16'd32768, 16'd39237, 16'd45316, 16'd50684, 16'd55138, 16'd58612, 16'd61158,
    16'd62911, 16'd64045, 16'd64735, 16'd65129, 16'd65341, 16'd65448, 16'd65498,
    16'd65521, 16'd65530, 16'd65534
  };

  // logistic(u) at 0, 0.5, ... 8.0
  localparam logic [15:0] SIGMOID_Q16 [17] = '{
    16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724, 16'd60565, 16'd62428,
    16'd63615, 16'd64357, 16'd64809, 16'd65097, 16'd65269, 16'd65374, 16'd65438,
    16'd65476, 16'd65500, 16'd65514
  };

  // zero, +-1 lsb, full scale, +-1.0, erf table end (4.0), tanh cutoff (5.0)
  localparam logic [15:0] CORNER_X [16] = '{
    16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0400, 16'hFC00, 16'h0FFF,
    16'h1000, 16'hF000, 16'h13FF, 16'h1400, 16'hEC00, 16'hF400, 16'hFE00, 16'hC000
  };

  typedef struct packed {
    logic [DATA_WIDTH-1:0] x;
    logic                  tanh_gate;
    logic [DATA_WIDTH-1:0] y;
  } gelu_expect_t;

  class gelu_scoreboard;
    gelu_expect_t expected_y[$];
    int errors;
    int n_checked;
    int n_erf;
    int n_tanh;

    function new();
      errors    = 0;
      n_checked = 0;
      n_erf     = 0;
      n_tanh    = 0;
    endfunction

    function logic [63:0] table_gate(input logic [15:0] tab [17], input logic [63:0] pos);
      logic [63:0] idx;
      logic [63:0] frac;
      logic [63:0] lo;
      logic [63:0] hi;
      idx  = pos >> FRAC_BITS;
      frac = pos & ((64'd1 << FRAC_BITS) - 64'd1);
      if (idx >= LAST_KNOT) return Q16_ONE;
      lo = 64'(tab[int'(idx)]);
      hi = 64'(tab[int'(idx) + 1]);
      return lo + (((hi - lo) * frac) >> FRAC_BITS);
    endfunction

    function logic [DATA_WIDTH-1:0] gelu_of(input logic [DATA_WIDTH-1:0] x,
                                            input logic tanh_gate);
      logic        neg;
      logic [63:0] a;
      logic [63:0] a2;
      logic [63:0] a3;
      logic [63:0] u;
      logic [63:0] g;
      logic [63:0] mag;
      logic [63:0] res;
      neg = x[DATA_WIDTH-1];
      a   = neg ? ((64'd1 << DATA_WIDTH) - 64'(x)) : 64'(x);
      if (!tanh_gate) begin
        g = table_gate(PHI_Q16, a * 64'd4);
      end else if (a >= (64'd5 << FRAC_BITS)) begin
        g = Q16_ONE;
      end else begin
        a2 = (a * a) >> FRAC_BITS;
        a3 = (a2 * a) >> FRAC_BITS;
        u  = (K_LINEAR * a + K_CUBIC * a3) >> 16;
        g  = table_gate(SIGMOID_Q16, u * 64'd2);
      end
      if (neg) g = Q16_ONE - g;
      mag = (a * g + Q16_HALF) >> 16;
      res = neg ? ((64'd1 << DATA_WIDTH) - mag) : mag;
      return res[DATA_WIDTH-1:0];
    endfunction

    function void note_sample(input logic [DATA_WIDTH-1:0] x, input logic tanh_gate);
      gelu_expect_t e;
      e.x         = x;
      e.tanh_gate = tanh_gate;
      e.y         = gelu_of(x, tanh_gate);
      expected_y.push_back(e);
    endfunction

    function int pending();
      return expected_y.size();
    endfunction

    task report(input string msg);
      if (errors < 200) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(input logic [DATA_WIDTH-1:0] y);
      gelu_expect_t e;
      if (expected_y.size() == 0) begin
        report($sformatf("y_out beat %0d with no sample pending", $signed(y)));
      end else begin
        e = expected_y.pop_front();
        n_checked++;
        if (e.tanh_gate) n_tanh++;
        else n_erf++;
        if (y !== e.y)
          report($sformatf("x=%0d mode=%0d: y_out %0d, expected %0d",
                           $signed(e.x), e.tanh_gate, $signed(y), $signed(e.y)));
      end
    endtask
  endclass

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         psel      = 1'b0;
  logic                         penable   = 1'b0;
  logic                         pwrite    = 1'b0;
  logic [ADDR_W-1:0]            paddr     = '0;
  logic [31:0]                  pwdata    = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic signed [DATA_WIDTH-1:0] x_in      = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [DATA_WIDTH-1:0] y_out;

  gelu_scoreboard sb = new();
  logic fast_mode_q = MODE_ERF;
  int   n_sent      = 0;
  int   idle_cycles = 0;
  bit   rx_free     = 1'b1;
  bit   rx_high     = 1'b1;
  int   rx_left     = 0;

  gelu_activation u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .x_in      (x_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .y_out     (y_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: alternating ready/stall stretches, or always ready
  always @(negedge clk) begin
    if (rx_free) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_left == 0) begin
        rx_high = !rx_high;
        rx_left = rx_high ? $urandom_range(1, 30) : $urandom_range(1, 6);
      end else begin
        rx_left--;
      end
      out_ready <= rx_high;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(y_out);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d still pending",
                 idle_cycles, sb.pending());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // all driving tasks start and end at a falling edge
  task automatic apb_write(input int idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == int'(REG_FAST_MODE)) fast_mode_q = data[0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // the bus goes idle before the next transfer
    @(negedge clk);
  endtask

  task automatic apb_read(input int idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.report($sformatf("register %0d reads %0h, expected %0h", idx, prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    logic [31:0] junk;
    junk = $urandom;
    apb_write(int'(REG_FAST_MODE), {junk[31:1], m});
    apb_read(int'(REG_FAST_MODE), {31'd0, m});
  endtask

  task automatic send_beat(input logic [DATA_WIDTH-1:0] x);
    in_valid <= 1'b1;
    x_in     <= x;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(x, fast_mode_q);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic logic [DATA_WIDTH-1:0] random_sample();
    case ($urandom_range(0, 3))
      0:       return DATA_WIDTH'($urandom);
      1:       return DATA_WIDTH'($urandom_range(0, 12288)) - DATA_WIDTH'(6144);
      2:       return DATA_WIDTH'($urandom_range(0, 2048)) - DATA_WIDTH'(1024);
      default: return DATA_WIDTH'($urandom_range(0, 16384)) - DATA_WIDTH'(8192);
    endcase
  endfunction

  task automatic send_random(input int n, input bit dense);
    int burst;
    int left;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_beat(random_sample());
      left -= burst;
      if (!dense && $urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
    end
    in_valid <= 1'b0;
  endtask

  task automatic send_corners();
    foreach (CORNER_X[i]) begin
      send_beat(CORNER_X[i]);
      if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 3));
    end
    in_valid <= 1'b0;
  endtask

  // wait for every expected beat, then let the pipeline settle before a register write
  task automatic drain();
    while (sb.pending() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    apb_read(int'(REG_FAST_MODE), {31'd0, MODE_ERF});

    rx_free = 1'b1;
    send_corners();
    drain();

    set_mode(MODE_TANH);
    rx_free = 1'b0;
    send_corners();
    drain();

    // unmapped register: mode must stay tanh
    apb_write(REG_SPARE, 32'hFFFF_FFFE);
    apb_read(int'(REG_FAST_MODE), {31'd0, MODE_TANH});
    send_random(400, 1'b0);
    drain();

    set_mode(MODE_ERF);
    send_random(400, 1'b0);
    drain();

    rx_free = 1'b1;
    send_random(300, 1'b1);
    drain();

    set_mode(MODE_TANH);
    rx_free = 1'b0;
    send_random(400, 1'b0);
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Checked %0d of %0d samples: %0d through the erf gate, %0d through the tanh gate",
             sb.n_checked, n_sent, sb.n_erf, sb.n_tanh);
    $display("Covered both gate modes, an unmapped register write, bursty input and output stalls");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> gelu_activation.f
src/gelu_pkg.sv
src/gelu_activation.sv
tb/tb.sv
